// File: src/palette_gradient_entry_top_assert.svh
// Assertion helpers for the palette gradient pipeline.
// Every check is gated off while rst_n is low.
`ifndef PALETTE_GRADIENT_ENTRY_TOP_ASSERT_SVH
`define PALETTE_GRADIENT_ENTRY_TOP_ASSERT_SVH
// Same-cycle implication.
`define PGE_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define PGE_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: src/pge_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pge_pkg;

  localparam int unsigned IDX_W      = 11;
  localparam int unsigned CNT_W      = 11;
  localparam int unsigned PAL_W      = 3;
  localparam int unsigned CH_W       = 8;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 11;

  // Requested count saturates here before rounding.
  localparam int unsigned MAX_STEPS = 1024;
  localparam int unsigned CNT_MAX   = (1 << CNT_W) - 1;
  localparam logic [CNT_W-1:0] N_CAP =
    CNT_W'((MAX_STEPS < CNT_MAX) ? MAX_STEPS : CNT_MAX);
  localparam logic [CNT_W-1:0] CNT_RESET = 11'd256;

  localparam int unsigned SEG_W    = 3;
  localparam int unsigned MUL_W    = 14;  // up to six times the part size
  localparam int unsigned NUM_W    = 19;  // 255 * d, d < 2^11
  localparam int unsigned KEY_N    = 24;
  localparam int unsigned KEY_W    = 5;
  localparam logic [KEY_W-1:0] KEY_LAST = 5'd22;

  // ceil(n/K) for K = 5, 6 by reciprocal multiply; exact for x < 2^12
  localparam int unsigned X_W    = 12;
  localparam int unsigned RCP_W  = 18;
  localparam int unsigned RCP_SH = 20;
  localparam logic [RCP_W-1:0] RCP5 = 18'd209716;
  localparam logic [RCP_W-1:0] RCP6 = 18'd174763;

  localparam int unsigned DIV_BPS    = 2;
  localparam int unsigned DIV_STAGES = CH_W / DIV_BPS;

  typedef enum logic [PAL_W-1:0] {
    PAL_IRON        = 3'd0,
    PAL_RAINBOW     = 3'd1,
    PAL_RAINBOW2    = 3'd2,
    PAL_BLUE_RED    = 3'd3,
    PAL_BLACK_WHITE = 3'd4
  } palette_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PALETTE_SELECT = 1'b0,
    REG_ENTRY_COUNT    = 1'b1
  } cfg_reg_t;

  typedef logic [2:0][CH_W-1:0] rgb_t;  // [2] red, [1] green, [0] blue

  typedef struct packed {
    logic [PAL_W-1:0] pal;
    logic [CNT_W-1:0] count;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [PAL_W-1:0] pal;
    logic             pal_ok;
    logic [CNT_W-1:0] part;
  } seg1_t;

  typedef struct packed {
    logic [PAL_W-1:0] pal;
    logic [SEG_W-1:0] seg;
    logic [CNT_W-1:0] s;
    logic [CNT_W-1:0] d;
    logic             in_range;
  } seg2_t;

  typedef struct packed {
    logic [2:0][NUM_W-1:0] num;
    logic [CNT_W-1:0]      d;
    rgb_t                  key_a;
    logic                  in_range;
  } num_t;

  typedef struct packed {
    logic [2:0][NUM_W-1:0] rem;
    rgb_t                  q;
    logic [CNT_W-1:0]      d;
    rgb_t                  key_a;
    logic                  in_range;
  } divst_t;

  typedef struct packed {
    rgb_t rgb;
    logic in_range;
  } res_t;

  // All key colors back to back, {red, green, blue}.
  localparam rgb_t KEY_RGB [KEY_N] = '{
    {8'h00, 8'h00, 8'h00}, {8'h20, 8'h00, 8'h8C}, {8'hCC, 8'h00, 8'h77},
    {8'hFF, 8'hD7, 8'h00}, {8'hFF, 8'hFF, 8'hFF},
    {8'd84, 8'd0, 8'd180}, {8'd0, 8'd97, 8'd211}, {8'd0, 8'd145, 8'd72},
    {8'd207, 8'd214, 8'd0}, {8'd231, 8'd108, 8'd0}, {8'd193, 8'd19, 8'd33},
    {8'd143, 8'd0, 8'd255}, {8'd75, 8'd0, 8'd130}, {8'd0, 8'd0, 8'd255},
    {8'd0, 8'd255, 8'd0}, {8'd255, 8'd255, 8'd0}, {8'd255, 8'd127, 8'd0},
    {8'd255, 8'd0, 8'd0},
    {8'h00, 8'h00, 8'hFF}, {8'hFF, 8'h00, 8'h00},
    {8'h00, 8'h00, 8'h00}, {8'hFF, 8'hFF, 8'hFF},
    {8'h00, 8'h00, 8'h00}, {8'h00, 8'h00, 8'h00}
  };

  function automatic logic [SEG_W-1:0] pal_segs(input logic [PAL_W-1:0] pal);
    logic [SEG_W-1:0] k;
    case (palette_t'(pal))
      PAL_IRON:        k = 3'd4;
      PAL_RAINBOW:     k = 3'd5;
      PAL_RAINBOW2:    k = 3'd6;
      PAL_BLUE_RED:    k = 3'd1;
      PAL_BLACK_WHITE: k = 3'd1;
      default:         k = 3'd0;
    endcase
    return k;
  endfunction

  function automatic logic [KEY_W-1:0] pal_first(input logic [PAL_W-1:0] pal);
    logic [KEY_W-1:0] f;
    case (palette_t'(pal))
      PAL_IRON:        f = 5'd0;
      PAL_RAINBOW:     f = 5'd5;
      PAL_RAINBOW2:    f = 5'd11;
      PAL_BLUE_RED:    f = 5'd18;
      PAL_BLACK_WHITE: f = 5'd20;
      default:         f = 5'd0;
    endcase
    return f;
  endfunction

endpackage
`default_nettype wire

// File: src/pge_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface pge_in_if import pge_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] entry_index;

  modport source (output valid, output entry_index, input ready);
  modport sink   (input valid, input entry_index, output ready);
endinterface

interface pge_out_if import pge_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;
  logic            in_range;

  modport source (output valid, output red, output green, output blue, output in_range,
                  input ready);
  modport sink   (input valid, input red, input green, input blue, input in_range,
                  output ready);
endinterface
`default_nettype wire

// File: src/palette_gradient_entry_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Palette gradient lookup: one color per entry index.
// in_ch carries entry_index; out_ch returns red, green, blue and in_range,
// one word per accepted index, in order. Both use valid/ready; a word moves
// on a clock edge with valid and ready high.
// cfg_we/cfg_index/cfg_data write palette_select (index 0) or entry_count
// (index 1); write only while no word is in flight.
// Throughput: one index per cycle while out_ch is not stalled. Registered
// steps from acceptance to out_ch.valid: part size, segment/offset, key
// lookup and blend numerator, then four stages of the 2-bit-per-stage
// divider, the last of which loads the output register.
// An index at or past the rounded count, or a palette number above 4,
// returns in_range 0 and black.
// Reset (rst_n low, synchronous) empties the pipeline and sets palette 0
// with 256 entries. When out_ch stalls, each stage holds its word and
// keeps accepting until the bubbles ahead of it are filled.
module palette_gradient_entry_top import pge_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  pge_in_if.sink                     in_ch,
  pge_out_if.source                  out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [PAL_W-1:0] pal_r;
  logic [CNT_W-1:0] count_r;
  cfg_t             cfg;

  logic  seg_valid, seg_ready;
  seg2_t seg_word;
  logic  num_valid, num_ready;
  num_t  num_word;
  res_t  res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pal_r   <= PAL_IRON;
      count_r <= CNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PALETTE_SELECT: pal_r   <= cfg_data[PAL_W-1:0];
        REG_ENTRY_COUNT:    count_r <= cfg_data[CNT_W-1:0];
      endcase
    end
  end

  assign cfg.pal   = pal_r;
  assign cfg.count = count_r;

  pge_seg_map u_seg_map (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_ch.valid),
    .in_idx    (in_ch.entry_index),
    .in_ready  (in_ch.ready),
    .out_valid (seg_valid),
    .out_seg   (seg_word),
    .out_ready (seg_ready)
  );

  pge_blend u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (seg_valid),
    .in_seg    (seg_word),
    .in_ready  (seg_ready),
    .out_valid (num_valid),
    .out_num   (num_word),
    .out_ready (num_ready)
  );

  pge_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (num_valid),
    .in_num    (num_word),
    .in_ready  (num_ready),
    .out_valid (out_ch.valid),
    .out_res   (res),
    .out_ready (out_ch.ready)
  );

  assign out_ch.red      = res.rgb[2];
  assign out_ch.green    = res.rgb[1];
  assign out_ch.blue     = res.rgb[0];
  assign out_ch.in_range = res.in_range;

endmodule
`default_nettype wire

// File: src/pge_seg_map.sv
`timescale 1ns / 1ps
`default_nettype none
`include "palette_gradient_entry_top_assert.svh"
module pge_seg_map import pge_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cfg_t             cfg,
  input  wire logic             in_valid,
  input  wire logic [IDX_W-1:0] in_idx,
  output logic                  in_ready,
  output logic                  out_valid,
  output seg2_t                 out_seg,
  input  wire logic             out_ready
);

  // stage 1: part size = ceil(n/K)
  logic [CNT_W-1:0]       n;
  logic [X_W-1:0]         x4, x5, x6;
  logic [X_W+RCP_W-1:0]   p5, p6;
  seg1_t                  s1_nxt, s1_r;
  logic                   s1_v_r;

  // stage 2: segment number and offset inside it
  logic [MUL_W-1:0] pt, id, m2, m3, m4, m5, m6, rounded, base_m;
  seg2_t            s2_nxt, s2_r;
  logic             s2_v_r;

  logic adv1, adv2;

  assign adv2     = !s2_v_r || out_ready;
  assign adv1     = !s1_v_r || adv2;
  assign in_ready = adv1;

  always_comb begin
    n  = (cfg.count > N_CAP) ? N_CAP : cfg.count;
    x4 = X_W'(n) + X_W'(3);
    x5 = X_W'(n) + X_W'(4);
    x6 = X_W'(n) + X_W'(5);
    p5 = x5 * RCP5;
    p6 = x6 * RCP6;
    s1_nxt.idx    = in_idx;
    s1_nxt.pal    = cfg.pal;
    s1_nxt.pal_ok = 1'b1;
    unique case (palette_t'(cfg.pal))
      PAL_IRON:        s1_nxt.part = CNT_W'(x4 >> 2);
      PAL_RAINBOW:     s1_nxt.part = CNT_W'(p5[X_W+RCP_W-1:RCP_SH]);
      PAL_RAINBOW2:    s1_nxt.part = CNT_W'(p6[X_W+RCP_W-1:RCP_SH]);
      PAL_BLUE_RED,
      PAL_BLACK_WHITE: s1_nxt.part = n;
      default: begin
        s1_nxt.part   = '0;
        s1_nxt.pal_ok = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv1) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      s1_r <= s1_nxt;
    end
  end

  always_comb begin
    pt = MUL_W'(s1_r.part);
    id = MUL_W'(s1_r.idx);
    m2 = pt << 1;
    m3 = m2 + pt;
    m4 = pt << 2;
    m5 = m4 + pt;
    m6 = m4 + m2;
    unique case (palette_t'(s1_r.pal))
      PAL_IRON:     rounded = m4;
      PAL_RAINBOW:  rounded = m5;
      PAL_RAINBOW2: rounded = m6;
      default:      rounded = pt;
    endcase
    // idx < K*part when in range, so seg never reaches K
    priority if (id >= m5) begin
      s2_nxt.seg = 3'd5;
      base_m     = m5;
    end else if (id >= m4) begin
      s2_nxt.seg = 3'd4;
      base_m     = m4;
    end else if (id >= m3) begin
      s2_nxt.seg = 3'd3;
      base_m     = m3;
    end else if (id >= m2) begin
      s2_nxt.seg = 3'd2;
      base_m     = m2;
    end else if (id >= pt) begin
      s2_nxt.seg = 3'd1;
      base_m     = pt;
    end else begin
      s2_nxt.seg = 3'd0;
      base_m     = '0;
    end
    s2_nxt.pal      = s1_r.pal;
    s2_nxt.s        = CNT_W'(id - base_m);
    s2_nxt.d        = s1_r.part - CNT_W'(1);
    s2_nxt.in_range = s1_r.pal_ok && (id < rounded);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv2) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && s1_v_r) begin
      s2_r <= s2_nxt;
    end
  end

  assign out_valid = s2_v_r;
  assign out_seg   = s2_r;

  `PGE_ASSERT_IMP(a_offset_in_part, clk, rst_n, s2_v_r && s2_r.in_range, s2_r.s <= s2_r.d, "offset past end of part")
  `PGE_ASSERT_IMP(a_seg_in_palette, clk, rst_n, s2_v_r && s2_r.in_range, s2_r.seg < pal_segs(s2_r.pal), "segment beyond palette")
  `PGE_ASSERT_NXT(a_stall_holds, clk, rst_n, s2_v_r && !out_ready, s2_v_r && $stable(s2_r), "stalled word changed")

endmodule
`default_nettype wire

// File: src/pge_blend.sv
`timescale 1ns / 1ps
`default_nettype none
module pge_blend import pge_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  input  wire seg2_t in_seg,
  output logic       in_ready,
  output logic       out_valid,
  output num_t       out_num,
  input  wire logic  out_ready
);

  logic [KEY_W-1:0] base_w, base;
  rgb_t             ka, kb;
  logic [CNT_W-1:0] ds;
  logic [2:0][NUM_W-1:0] pa, pb;
  num_t             num_nxt, num_r;
  logic             v_r;
  logic             adv;

  assign adv      = !v_r || out_ready;
  assign in_ready = adv;

  always_comb begin
    base_w = pal_first(in_seg.pal) + KEY_W'(in_seg.seg);
    base   = (base_w > KEY_LAST) ? KEY_LAST : base_w;
    ka     = KEY_RGB[base];
    kb     = KEY_RGB[KEY_W'(base + KEY_W'(1))];
    ds     = in_seg.d - in_seg.s;
    for (int c = 0; c < 3; c++) begin
      // a*(d-s) + b*s, at most 255*d
      pa[c] = NUM_W'(ka[c]) * NUM_W'(ds);
      pb[c] = NUM_W'(kb[c]) * NUM_W'(in_seg.s);
      num_nxt.num[c] = pa[c] + pb[c];
    end
    num_nxt.d        = in_seg.d;
    num_nxt.key_a    = ka;
    num_nxt.in_range = in_seg.in_range;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      num_r <= num_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_num   = num_r;

endmodule
`default_nettype wire

// File: src/pge_div.sv
`timescale 1ns / 1ps
`default_nettype none
`include "palette_gradient_entry_top_assert.svh"
module pge_div import pge_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire num_t in_num,
  output logic      in_ready,
  output logic      out_valid,
  output res_t      out_res,
  input  wire logic out_ready
);

  // Restoring division, DIV_BPS quotient bits per stage; the last stage
  // also selects the color and loads the output register.
  localparam int unsigned NREG = DIV_STAGES - 1;

  function automatic divst_t div_steps(input divst_t x, input int unsigned hi);
    divst_t           y;
    logic [NUM_W-1:0] trial;
    logic             ge;
    y = x;
    for (int j = 0; j < DIV_BPS; j++) begin
      for (int c = 0; c < 3; c++) begin
        trial = NUM_W'(y.d) << (hi - j);
        ge    = (y.rem[c] >= trial);
        if (ge) begin
          y.rem[c] = y.rem[c] - trial;
        end
        y.q[c] = {y.q[c][CH_W-2:0], ge};
      end
    end
    return y;
  endfunction

  divst_t first_in;
  divst_t st_nxt [DIV_STAGES];
  divst_t st_r   [NREG];
  logic   v_r    [NREG];
  logic   up_v   [NREG+1];
  logic   adv    [NREG+1];
  divst_t fin;
  res_t   res_nxt, out_res_r;
  logic   out_valid_r;

  always_comb begin
    first_in.rem      = in_num.num;
    first_in.q        = '0;
    first_in.d        = in_num.d;
    first_in.key_a    = in_num.key_a;
    first_in.in_range = in_num.in_range;
  end

  assign up_v[0]    = in_valid;
  assign adv[NREG]  = !out_valid_r || out_ready;
  assign in_ready   = adv[0];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_step
    if (g == 0) begin : g_first
      assign st_nxt[g] = div_steps(first_in, CH_W - 1);
    end else begin : g_next
      assign st_nxt[g] = div_steps(st_r[g-1], CH_W - 1 - g * DIV_BPS);
    end
  end

  for (genvar g = 0; g < NREG; g++) begin : g_reg
    assign adv[g]    = !v_r[g] || adv[g+1];
    assign up_v[g+1] = v_r[g];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (adv[g]) begin
        v_r[g] <= up_v[g];
      end
    end

    always_ff @(posedge clk) begin
      if (adv[g] && up_v[g]) begin
        st_r[g] <= st_nxt[g];
      end
    end
  end

  assign fin = st_nxt[DIV_STAGES-1];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (!fin.in_range) begin
        res_nxt.rgb[c] = '0;
      end else if (fin.d == '0) begin
        res_nxt.rgb[c] = fin.key_a[c];
      end else begin
        res_nxt.rgb[c] = fin.q[c];
      end
    end
    res_nxt.in_range = fin.in_range;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv[NREG]) begin
      out_valid_r <= up_v[NREG];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[NREG] && up_v[NREG]) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // after the first stage the partial remainder is below d << (bits left)
  `PGE_ASSERT_IMP(a_rem_bound, clk, rst_n, v_r[0] && st_r[0].in_range && (st_r[0].d != '0), (st_r[0].rem[0] < (NUM_W'(st_r[0].d) << (CH_W - DIV_BPS))) && (st_r[0].rem[1] < (NUM_W'(st_r[0].d) << (CH_W - DIV_BPS))) && (st_r[0].rem[2] < (NUM_W'(st_r[0].d) << (CH_W - DIV_BPS))), "partial remainder too large")
  `PGE_ASSERT_IMP(a_out_of_range_black, clk, rst_n, out_valid_r && !out_res_r.in_range, out_res_r.rgb == '0, "out-of-range word has color")

endmodule
`default_nettype wire
